// ===== rtl/core/stbs_pkg.sv =====
package stbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam int KEY_W   = 32;
   localparam int INDEX_W = 10;
   localparam int SIZE_W  = 11;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANGE,
      ST_COMPARE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic write_entry;
      logic load;
      logic issue;
      logic step;
      logic finish_hit;
      logic finish_miss;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic range_open;
      logic key_equal;
   } dp_status_type;

endpackage

// ===== rtl/core/stbs_ctrl.sv =====
module stbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_command,
   input  stbs_pkg::dp_status_type status,
   output stbs_pkg::dp_cmd_type   cmd,
   output logic                   busy
);
   import stbs_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_command == CMD_SEARCH) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (status.range_open) begin
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COMPARE: begin
            if (status.key_equal) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RANGE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy             = 1'b0;
            cmd.write_entry  = start && req_command == CMD_WRITE;
            cmd.load         = start && req_command == CMD_SEARCH;
         end
         ST_RANGE: begin
            cmd.issue        = status.range_open;
            cmd.finish_miss  = !status.range_open;
         end
         ST_COMPARE: begin
            cmd.finish_hit   = status.key_equal;
            cmd.step         = !status.key_equal;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/stbs_datapath.sv =====
module stbs_datapath #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stbs_pkg::dp_cmd_type                 cmd,
   output stbs_pkg::dp_status_type              status,
   input  logic                                 csr_wr_en,
   input  logic [stbs_pkg::SIZE_W-1:0]          csr_wr_data,
   input  logic [stbs_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [stbs_pkg::KEY_W-1:0]    req_entry_value,
   input  logic signed [stbs_pkg::KEY_W-1:0]    req_search_key,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]         rsp_found_index
);
   import stbs_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // Bounds run 0..TABLE_DEPTH, so one more value than an address
   localparam int SPAN_W = $clog2(TABLE_DEPTH + 1);

   logic signed [KEY_W-1:0] table_ff [TABLE_DEPTH];
   logic signed [KEY_W-1:0] entry_ff;

   logic [SIZE_W-1:0]  size_ff;
   logic [SPAN_W-1:0]  span;
   logic [SPAN_W-1:0]  low_ff, low_in;
   logic [SPAN_W-1:0]  high_p1_ff, high_p1_in;   // upper bound plus one
   logic [SPAN_W-1:0]  half;
   logic [ADDR_W-1:0]  mid;
   logic [ADDR_W-1:0]  mid_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic               valid_ff;
   logic               found_ff;
   logic [INDEX_W-1:0] index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Clamp the size to the table depth
   always_comb begin
      if (32'(size_ff) > TABLE_DEPTH) begin
         span = SPAN_W'(TABLE_DEPTH);
      end else begin
         span = SPAN_W'(size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && 32'(req_entry_index) < TABLE_DEPTH) begin
         table_ff[ADDR_W'(req_entry_index)] <= req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         entry_ff <= table_ff[mid];
      end
   end

   assign half = SPAN_W'(high_p1_ff - low_ff - SPAN_W'(1)) >> 1;
   assign mid  = ADDR_W'(low_ff + half);

   assign status.range_open = low_ff < high_p1_ff;
   assign status.key_equal  = entry_ff == key_ff;

   always_comb begin
      low_in     = low_ff;
      high_p1_in = high_p1_ff;
      if (cmd.load) begin
         low_in     = '0;
         high_p1_in = span;
      end else if (cmd.step) begin
         if (entry_ff < key_ff) begin
            low_in = SPAN_W'(mid_ff) + SPAN_W'(1);
         end else begin
            high_p1_in = SPAN_W'(mid_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff     <= low_in;
      high_p1_ff <= high_p1_in;
      if (cmd.load) begin
         key_ff <= req_search_key;
      end
      if (cmd.issue) begin
         mid_ff <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish_hit || cmd.finish_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_hit) begin
         found_ff <= 1'b1;
         index_ff <= INDEX_W'(mid_ff);
      end else if (cmd.finish_miss) begin
         found_ff <= 1'b0;
         index_ff <= '0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_index = index_ff;

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// Channel  | Ports                                         | Transfer when
// ---------+-----------------------------------------------+---------------------
// request  | start, busy, req_command, req_entry_index,    | start && !busy
//          | req_entry_value, req_search_key               |
// response | rsp_valid, rsp_found, rsp_found_index         | rsp_valid (1 cycle)
// config   | csr_wr_en, csr_wr_data (table_size)           | csr_wr_en
//
// A write request gives no response. A search raises rsp_valid once its
// last probe hits, or once its bounds close on a miss, and busy drops in
// that same cycle; each probe is one registered read of the table memory
// and one compare (at most 11 for 1024). Reset is synchronous, active high,
// and clears the state machine, the response strobe and table_size; the
// table itself is not cleared. No stalls.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [stbs_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [stbs_pkg::KEY_W-1:0]    req_entry_value,
   input  logic signed [stbs_pkg::KEY_W-1:0]    req_search_key,
   // response channel
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]         rsp_found_index,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [stbs_pkg::SIZE_W-1:0]          csr_wr_data
);
   import stbs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller: sequence the probes, hold busy until the result is set
   stbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Datapath: table memory, search bounds, compare and result registers
   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index)
   );

endmodule
